>>> rtl/adlft_pkg.sv
// ----------------------------------------------------------------------------
// adlft_pkg
// Shared types and constants of the audio DMA length queue and playback timer.
// ----------------------------------------------------------------------------
package adlft_pkg;

  localparam int unsigned LEN_W         = 18;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CLK_W         = 26;
  localparam int unsigned DAC_W         = 14;

  localparam logic [CLK_W-1:0] NTSC_CLOCK = 26'd48681812;
  localparam logic [CLK_W-1:0] PAL_CLOCK  = 26'd49656530;
  localparam logic [LEN_W-1:0] LEN_MASK   = 18'h3FFF8;
  localparam logic [LEN_W-1:0] FIELD_MAX  = 18'h3FFFF;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DAC_RATE = 2'd0,
    CFG_BIT_RATE = 2'd1,
    CFG_PAL_MODE = 2'd2,
    CFG_VCPF     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    op_e              operation;
    logic [LEN_W-1:0] length;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] remaining_bytes;
    logic             dma_busy;
    logic             fifo_full;
    logic             overflow_error;
    logic             buffer_done;
    logic             interrupt_raise;
  } result_t;

endpackage

>>> rtl/adlft_front.sv
// ----------------------------------------------------------------------------
// adlft_front
// Command intake: takes items and holds them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module adlft_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  adlft_pkg::item_t item_i,
  output logic           busy,
  input  logic           pop_i,
  output logic           valid_o,
  output adlft_pkg::item_t item_o
);
  import adlft_pkg::*;

  item_t      slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       push;

  assign busy    = (count_q == 2'd2);
  assign push    = start && !busy;
  assign valid_o = (count_q != 2'd0);
  assign item_o  = slot_q[rptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

>>> rtl/adlft_div.sv
// ----------------------------------------------------------------------------
// adlft_div
// Restoring divider, one quotient bit per cycle; divisor is never zero.
// ----------------------------------------------------------------------------
module adlft_div #(
  parameter int unsigned NUM_W = 54,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             run_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  // one restoring step
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign take  = !diff[DEN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(NUM_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (run_q) begin
      rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/adlft_back.sv
// ----------------------------------------------------------------------------
// adlft_back
// Executes queued items: length queue, timer, fixed-point scaling and divides.
// ----------------------------------------------------------------------------
module adlft_back #(
  parameter int unsigned FRACTION_BITS = adlft_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adlft_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [adlft_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                valid_i,
  input  adlft_pkg::item_t                    item_i,
  output logic                                pop_o,
  output logic                                result_valid_o,
  output adlft_pkg::result_t                  result_o
);
  import adlft_pkg::*;

  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned CPB_W = 32 + F;
  localparam int unsigned NUM_W = 38 + F;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_FREQ      = 11'b00000000010,
    ST_CPB_MUL   = 11'b00000000100,
    ST_CPB_CHK   = 11'b00000001000,
    ST_CPB_DIV   = 11'b00000010000,
    ST_PLACE     = 11'b00000100000,
    ST_SCALE_MUL = 11'b00001000000,
    ST_SCALE_ADD = 11'b00010000000,
    ST_BRANCH    = 11'b00100000000,
    ST_READ_DIV  = 11'b01000000000,
    ST_OUT       = 11'b10000000000
  } state_e;

  state_e state_q;

  // configuration
  logic [DAC_W-1:0] dac_q;
  logic [3:0]       br_q;
  logic             pal_q, clk_sel_q, freq_pend_q;
  logic [31:0]      vcpf_q;

  // block state
  logic [LEN_W-1:0] q0_q, q1_q, last_len_q;
  logic             busy_q, full_q;
  logic [31:0]      elapsed_q, dur_q, cached_q;
  logic [CPB_W-1:0] cpb_q;
  logic [CLK_W-1:0] freq_q;

  // working registers
  op_e              op_q;
  logic [LEN_W-1:0] len_q, slen_q;
  logic [37:0]      num_q;
  logic [28:0]      den_q;
  logic [49:0]      pint_q;
  logic [F+LEN_W-1:0] pfrac_q;
  logic [31:0]      dcalc_q;
  logic [LEN_W-1:0] rem_q;
  logic             ovf_q, done_q, irq_q;
  logic             res_valid_q;
  result_t          res_q;

  // divider hookup
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [CPB_W-1:0] div_den;
  logic [31:0]      rc;
  logic [50:0]      psum;
  logic [31:0]      elapsed_n;
  logic [LEN_W-1:0] len_m;

  assign rc        = dcalc_q - elapsed_q;
  assign psum      = 51'(pint_q) + 51'(pfrac_q >> F);
  assign elapsed_n = elapsed_q + 32'd1;
  assign len_m     = len_q & LEN_MASK;
  assign pop_o     = (state_q == ST_IDLE) && !freq_pend_q && valid_i;

  // divider launch and operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'({rc, {F{1'b0}}});
    div_den   = cpb_q;
    if (state_q == ST_IDLE) begin
      div_start = freq_pend_q;
      div_num   = NUM_W'(clk_sel_q ? PAL_CLOCK : NTSC_CLOCK);
      div_den   = CPB_W'({1'b0, dac_q} + 15'd1);
    end else if (state_q == ST_CPB_CHK) begin
      div_start = (den_q != '0);
      div_num   = {num_q, {F{1'b0}}};
      div_den   = CPB_W'(den_q);
    end else if (state_q == ST_BRANCH) begin
      div_start = (op_q == OP_READ) && (cpb_q != '0);
    end
  end

  adlft_div #(
    .NUM_W (NUM_W),
    .DEN_W (CPB_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dac_q       <= '0;
      br_q        <= '0;
      pal_q       <= 1'b0;
      clk_sel_q   <= 1'b0;
      vcpf_q      <= '0;
      freq_pend_q <= 1'b0;
    end else begin
      if (state_q == ST_IDLE && freq_pend_q) freq_pend_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DAC_RATE: begin
            dac_q       <= cfg_data_i[DAC_W-1:0];
            clk_sel_q   <= pal_q;
            freq_pend_q <= 1'b1;
          end
          CFG_BIT_RATE: br_q   <= cfg_data_i[3:0];
          CFG_PAL_MODE: pal_q  <= cfg_data_i[0];
          CFG_VCPF:     vcpf_q <= cfg_data_i[31:0];
          default:      ;
        endcase
      end
    end
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q0_q        <= '0;
      q1_q        <= '0;
      last_len_q  <= '0;
      busy_q      <= 1'b0;
      full_q      <= 1'b0;
      elapsed_q   <= '0;
      dur_q       <= '0;
      cached_q    <= '0;
      cpb_q       <= '0;
      freq_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (freq_pend_q) begin
            state_q <= ST_FREQ;
          end else if (valid_i) begin
            op_q  <= item_i.operation;
            len_q <= item_i.length;
            rem_q <= '0;
            ovf_q <= 1'b0;
            done_q <= 1'b0;
            irq_q <= 1'b0;
            state_q <= ST_OUT;
            unique case (item_i.operation)
              OP_WRITE: begin
                last_len_q <= item_i.length;
                if (item_i.length != '0) begin
                  if (cached_q != vcpf_q) begin
                    cached_q <= vcpf_q;
                    state_q  <= ST_CPB_MUL;
                  end else begin
                    state_q <= ST_PLACE;
                  end
                end
              end
              OP_READ: begin
                if (q0_q != '0) begin
                  slen_q  <= q0_q;
                  state_q <= ST_SCALE_MUL;
                end
              end
              OP_TICK: begin
                elapsed_q <= elapsed_n;
                if (dur_q != '0 && elapsed_n >= dur_q) begin
                  done_q <= 1'b1;
                  q0_q   <= q1_q;
                  q1_q   <= '0;
                  full_q <= 1'b0;
                  if (q1_q != '0) begin
                    busy_q  <= 1'b1;
                    slen_q  <= q1_q;
                    state_q <= ST_SCALE_MUL;
                  end else begin
                    busy_q <= 1'b0;
                    dur_q  <= '0;
                  end
                end
              end
              OP_CLEAR: begin
                cached_q <= '0;
                q0_q     <= '0;
                q1_q     <= '0;
                busy_q   <= 1'b0;
                full_q   <= 1'b0;
                dur_q    <= '0;
                if (last_len_q != '0) begin
                  elapsed_q <= '0;
                  irq_q     <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FREQ: begin
          if (div_done) begin
            freq_q  <= div_quot[CLK_W-1:0];
            state_q <= ST_IDLE;
          end
        end
        ST_CPB_MUL: begin
          num_q   <= {6'd0, vcpf_q} * (pal_q ? 38'd50 : 38'd60);
          den_q   <= 29'(freq_q) * 29'((5'(br_q) + 5'd1) >> 2);
          state_q <= ST_CPB_CHK;
        end
        ST_CPB_CHK: begin
          if (den_q == '0) begin
            cpb_q   <= '1;
            state_q <= ST_PLACE;
          end else begin
            state_q <= ST_CPB_DIV;
          end
        end
        ST_CPB_DIV: begin
          if (div_done) begin
            cpb_q   <= (div_quot[NUM_W-1:CPB_W] != '0) ? '1 : div_quot[CPB_W-1:0];
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          state_q <= ST_OUT;
          if (q0_q == '0) begin
            q0_q    <= len_m;
            busy_q  <= 1'b1;
            slen_q  <= len_m;
            state_q <= ST_SCALE_MUL;
          end else if (q1_q == '0) begin
            q1_q   <= len_m;
            full_q <= 1'b1;
          end else begin
            full_q <= 1'b1;
            ovf_q  <= 1'b1;
          end
        end
        ST_SCALE_MUL: begin
          pint_q  <= 50'(cpb_q[CPB_W-1:F]) * 50'(slen_q);
          pfrac_q <= (F+LEN_W)'(cpb_q[F-1:0]) * (F+LEN_W)'(slen_q);
          state_q <= ST_SCALE_ADD;
        end
        ST_SCALE_ADD: begin
          dcalc_q <= (psum[50:32] != '0) ? 32'hFFFF_FFFF : psum[31:0];
          state_q <= ST_BRANCH;
        end
        ST_BRANCH: begin
          state_q <= ST_OUT;
          if (op_q == OP_READ) begin
            if (cpb_q == '0) begin
              rem_q <= FIELD_MAX;
            end else begin
              state_q <= ST_READ_DIV;
            end
          end else begin
            dur_q     <= dcalc_q;
            elapsed_q <= '0;
          end
        end
        ST_READ_DIV: begin
          if (div_done) begin
            rem_q   <= (div_quot[NUM_W-1:LEN_W] != '0) ? FIELD_MAX : div_quot[LEN_W-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          res_valid_q <= 1'b1;
          res_q       <= '{remaining_bytes: rem_q, dma_busy: busy_q, fifo_full: full_q,
                           overflow_error: ovf_q, buffer_done: done_q,
                           interrupt_raise: irq_q};
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

>>> rtl/audio_dma_length_fifo_timer_unit.sv
// ----------------------------------------------------------------------------
// audio_dma_length_fifo_timer_unit
// Audio DMA length queue with playback timer and bytes-remaining readout.
//
//   channel  | signals                                  | transfer when
//   ---------+------------------------------------------+----------------------
//   command  | start, busy, item_i                      | start && !busy
//   result   | result_valid_o, result_o                 | result_valid_o
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i          | cfg_we_i
//
// Ticks, clears and plain writes need no divide; a read of a busy buffer and a
// write that refreshes counts per byte each add one pass of the shared
// bit-serial divider, which yields 38 + FRACTION_BITS quotient bits per pass.
// A dac_rate write runs the same divider once before the next item starts.
// Two commands can wait in the intake queue; busy is high while it is full.
// Reset is asynchronous and leaves the queue empty and the control state cleared.
// The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module audio_dma_length_fifo_timer_unit #(
  parameter int unsigned FRACTION_BITS = adlft_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  adlft_pkg::item_t                 item_i,
  output logic                             result_valid_o,
  output adlft_pkg::result_t               result_o,
  input  logic                             cfg_we_i,
  input  logic [adlft_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [adlft_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import adlft_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  // command intake
  adlft_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // execution
  adlft_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .pop_o          (q_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
